>>> hw/rtl/dwp_pkg.sv
// Package for the display window pixel stream unit.
// Holds the descriptor type, the mode and kind codes and the panel command bytes.
// No dependencies.
package dwp_pkg;

	// Request modes, carried on the slave tuser port.
	localparam logic [2:0] MODE_WINDOW = 3'd0;
	localparam logic [2:0] MODE_RGB565 = 3'd1;
	localparam logic [2:0] MODE_RGB888 = 3'd2;
	localparam logic [2:0] MODE_ORIENT = 3'd3;
	localparam logic [2:0] MODE_RAW_CMD = 3'd4;
	localparam logic [2:0] MODE_RAW_DATA = 3'd5;

	// Panel command bytes.
	localparam logic [7:0] CMD_COLUMN_ADDR = 8'h2A;
	localparam logic [7:0] CMD_ROW_ADDR = 8'h2B;
	localparam logic [7:0] CMD_MEMORY_WRITE = 8'h2C;
	localparam logic [7:0] CMD_ORIENTATION = 8'h36;

	// Default depth of the queue between front and back.
	localparam int QUEUE_DEPTH = 2;

	// Kinds of work the back end knows how to emit.
	localparam logic [1:0] KIND_WINDOW = 2'd0; // eleven-byte window sequence
	localparam logic [1:0] KIND_WORD = 2'd1;   // two data bytes, high first
	localparam logic [1:0] KIND_ORIENT = 2'd2; // orientation command plus one data byte
	localparam logic [1:0] KIND_SINGLE = 2'd3; // one byte, command or data

	// Classified request. For a window the payload is
	// {end_row, start_row, end_col, start_col}; otherwise the low bits hold the word or byte.
	typedef struct packed {
		logic [1:0]  kind;
		logic        is_data;
		logic [63:0] payload;
	} dwp_desc_t;

	typedef struct packed {
		logic pop;
		logic busy_window;
		logic [3:0] idx;
	} dwp_back_status_t;

endpackage

>>> hw/rtl/dwp_front.sv
// Front end of the display window pixel stream unit: accepts requests and
// classifies them into descriptors, with one register stage. Depends on dwp_pkg.
module dwp_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [95:0]       s_tdata,
	input  logic [2:0]        s_tuser,
	output logic              q_wr_valid,
	input  logic              q_wr_ready,
	output dwp_pkg::dwp_desc_t q_wr_desc
);
	import dwp_pkg::*;

	logic [15:0] start_col;
	logic [15:0] start_row;
	logic [15:0] win_width;
	logic [15:0] win_height;
	logic [23:0] pixel_color;
	logic [7:0]  byte_value;
	logic [15:0] end_col;
	logic [15:0] end_row;
	logic        keep;
	logic        accept;
	dwp_desc_t   desc_d;
	logic        valid_s1;
	dwp_desc_t   desc_s1;

	assign start_col = s_tdata[15:0];
	assign start_row = s_tdata[31:16];
	assign win_width = s_tdata[47:32];
	assign win_height = s_tdata[63:48];
	assign pixel_color = s_tdata[87:64];
	assign byte_value = s_tdata[95:88];

	// End coordinates wrap in 16 bits.
	assign end_col = start_col + win_width - 16'd1;
	assign end_row = start_row + win_height - 16'd1;

	always_comb begin
		keep = 1'b1;
		desc_d.kind = KIND_SINGLE;
		desc_d.is_data = 1'b0;
		desc_d.payload = '0;
		case (s_tuser)
			MODE_WINDOW: begin
				desc_d.kind = KIND_WINDOW;
				desc_d.payload = {end_row, start_row, end_col, start_col};
			end
			MODE_RGB565: begin
				desc_d.kind = KIND_WORD;
				desc_d.payload[15:0] = pixel_color[15:0];
			end
			MODE_RGB888: begin
				desc_d.kind = KIND_WORD;
				desc_d.payload[15:0] = {pixel_color[23:19], pixel_color[15:10], pixel_color[7:3]};
			end
			MODE_ORIENT: begin
				desc_d.kind = KIND_ORIENT;
				desc_d.payload[7:0] = byte_value;
			end
			MODE_RAW_CMD: begin
				desc_d.payload[7:0] = byte_value;
			end
			MODE_RAW_DATA: begin
				desc_d.is_data = 1'b1;
				desc_d.payload[7:0] = byte_value;
			end
			default: begin
				// Undefined modes are taken and dropped.
				keep = 1'b0;
			end
		endcase
	end

	assign s_tready = !valid_s1 || q_wr_ready;
	assign accept = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= keep;
		end else if (q_wr_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			desc_s1 <= desc_d;
		end
	end

	assign q_wr_valid = valid_s1;
	assign q_wr_desc = desc_s1;

endmodule

>>> hw/rtl/dwp_queue.sv
// Short descriptor queue between the front and back ends of the display window
// pixel stream unit. Depends on dwp_pkg.
module dwp_queue #(
	parameter int DEPTH = dwp_pkg::QUEUE_DEPTH,
	localparam int PTR_W = $clog2(DEPTH),
	localparam int CNT_W = $clog2(DEPTH + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_valid,
	output logic               wr_ready,
	input  dwp_pkg::dwp_desc_t wr_desc,
	output logic               rd_valid,
	input  logic               rd_pop,
	output dwp_pkg::dwp_desc_t rd_desc,
	output logic [CNT_W-1:0]   count
);
	import dwp_pkg::*;

	dwp_desc_t        mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	assign wr_ready = count_q != CNT_W'(DEPTH);
	assign rd_valid = count_q != '0;
	assign do_wr = wr_valid && wr_ready;
	assign do_rd = rd_pop && rd_valid;
	assign rd_desc = mem_q[rd_ptr_q];
	assign count = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_desc;
		end
	end

endmodule

>>> hw/rtl/dwp_back.sv
// Back end of the display window pixel stream unit: walks each descriptor byte
// by byte into the output register. Depends on dwp_pkg.
module dwp_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      head_valid,
	input  dwp_pkg::dwp_desc_t        head_desc,
	output logic                      head_pop,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [7:0]                m_tdata,
	output logic                      m_tuser,
	output logic                      m_tlast,
	output dwp_pkg::dwp_back_status_t status
);
	import dwp_pkg::*;

	// Byte positions within the window sequence.
	localparam logic [3:0] POS_COL_CMD = 4'd0;
	localparam logic [3:0] POS_COL_SHI = 4'd1;
	localparam logic [3:0] POS_COL_SLO = 4'd2;
	localparam logic [3:0] POS_COL_EHI = 4'd3;
	localparam logic [3:0] POS_COL_ELO = 4'd4;
	localparam logic [3:0] POS_ROW_CMD = 4'd5;
	localparam logic [3:0] POS_ROW_SHI = 4'd6;
	localparam logic [3:0] POS_ROW_SLO = 4'd7;
	localparam logic [3:0] POS_ROW_EHI = 4'd8;
	localparam logic [3:0] POS_ROW_ELO = 4'd9;
	localparam logic [3:0] POS_MEM_WR = 4'd10;

	logic [3:0] idx_q;
	logic [7:0] nxt_byte;
	logic       nxt_data;
	logic       nxt_last;
	logic       advance;
	logic       m_tvalid_q;
	logic [7:0] m_byte_q;
	logic       m_data_q;
	logic       m_last_q;

	always_comb begin
		nxt_byte = head_desc.payload[7:0];
		nxt_data = 1'b1;
		nxt_last = 1'b0;
		case (head_desc.kind)
			KIND_WINDOW: begin
				case (idx_q)
					POS_COL_CMD: begin
						nxt_byte = CMD_COLUMN_ADDR;
						nxt_data = 1'b0;
					end
					POS_COL_SHI: nxt_byte = head_desc.payload[15:8];
					POS_COL_SLO: nxt_byte = head_desc.payload[7:0];
					POS_COL_EHI: nxt_byte = head_desc.payload[31:24];
					POS_COL_ELO: nxt_byte = head_desc.payload[23:16];
					POS_ROW_CMD: begin
						nxt_byte = CMD_ROW_ADDR;
						nxt_data = 1'b0;
					end
					POS_ROW_SHI: nxt_byte = head_desc.payload[47:40];
					POS_ROW_SLO: nxt_byte = head_desc.payload[39:32];
					POS_ROW_EHI: nxt_byte = head_desc.payload[63:56];
					POS_ROW_ELO: nxt_byte = head_desc.payload[55:48];
					default: begin
						nxt_byte = CMD_MEMORY_WRITE;
						nxt_data = 1'b0;
						nxt_last = 1'b1;
					end
				endcase
			end
			KIND_WORD: begin
				nxt_byte = (idx_q == 4'd0) ? head_desc.payload[15:8] : head_desc.payload[7:0];
				nxt_last = idx_q != 4'd0;
			end
			KIND_ORIENT: begin
				if (idx_q == 4'd0) begin
					nxt_byte = CMD_ORIENTATION;
					nxt_data = 1'b0;
				end else begin
					nxt_last = 1'b1;
				end
			end
			default: begin
				nxt_data = head_desc.is_data;
				nxt_last = 1'b1;
			end
		endcase
	end

	assign advance = head_valid && (!m_tvalid_q || m_tready);
	assign head_pop = advance && nxt_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (advance) begin
				idx_q <= nxt_last ? 4'd0 : idx_q + 4'd1;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			m_byte_q <= nxt_byte;
			m_data_q <= nxt_data;
			m_last_q <= nxt_last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_byte_q;
	assign m_tuser = m_data_q;
	assign m_tlast = m_last_q;

	assign status.pop = head_pop;
	assign status.busy_window = head_valid && (head_desc.kind == KIND_WINDOW);
	assign status.idx = idx_q;

endmodule

>>> hw/rtl/display_window_pixel_stream_unit.sv
// Top level of the display window pixel stream unit: turns display requests
// into a tagged command/data byte stream. Depends on dwp_pkg, dwp_front, dwp_queue, dwp_back.
//
//  channel | dir | signals                                  | one word is
//  --------+-----+------------------------------------------+-------------------------------
//  s_*     | in  | s_tvalid s_tready s_tdata[95:0] s_tuser  | one display request
//  m_*     | out | m_tvalid m_tready m_tdata[7:0] m_tuser   | one byte for the panel
//          |     | m_tlast                                  |
//
// Each request yields its bytes in order: a window gives 11 words, a pixel 2,
// an orientation request 2 and a raw byte 1, all set by the back end's byte sequencer,
// which emits one byte per cycle into the output register while m_tready does not stall it.
// The front end takes a new request every cycle while the queue has room, so with
// back-to-back requests a pixel stream is paced by the back end's two bytes per pixel.
// Undefined modes are accepted and yield no word.
// Reset is asynchronous and clears the front stage, queue pointers, byte counter and
// output valid; the first request may be taken in the cycle after reset is released.
// A stall on m_tready holds the output word; requests then fill the front stage and
// queue, after which s_tready drops until the back end drains.
module display_window_pixel_stream_unit #(
	parameter int QDEPTH = dwp_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// s_tdata, lowest bit up: start_col[15:0], start_row[31:16], win_width[47:32],
	// win_height[63:48], pixel_color[87:64], byte_value[95:88]
	input  logic [95:0] s_tdata,
	// s_tuser: mode[2:0]
	input  logic [2:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// m_tdata: out_byte[7:0]
	output logic [7:0]  m_tdata,
	// m_tuser: is_data[0], high for a data byte and low for a command byte
	output logic        m_tuser,
	// m_tlast: last_byte, high on the final word of a request
	output logic        m_tlast
);
	import dwp_pkg::*;

	localparam int CNT_W = $clog2(QDEPTH + 1);

	logic             q_wr_valid;
	logic             q_wr_ready;
	dwp_desc_t        q_wr_desc;
	logic             q_rd_valid;
	logic             q_pop;
	dwp_desc_t        q_rd_desc;
	logic [CNT_W-1:0] q_count;
	dwp_back_status_t back_status;

	// Front end: accepts and classifies requests, computes window end coordinates.
	dwp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.q_wr_valid (q_wr_valid),
		.q_wr_ready (q_wr_ready),
		.q_wr_desc  (q_wr_desc)
	);

	// Descriptor queue that lets the front and back stall independently.
	dwp_queue #(
		.DEPTH (QDEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (q_wr_valid),
		.wr_ready (q_wr_ready),
		.wr_desc  (q_wr_desc),
		.rd_valid (q_rd_valid),
		.rd_pop   (q_pop),
		.rd_desc  (q_rd_desc),
		.count    (q_count)
	);

	// Back end: walks the head descriptor out one byte per cycle while m_tready does not stall it.
	dwp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (q_rd_valid),
		.head_desc  (q_rd_desc),
		.head_pop   (q_pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast),
		.status     (back_status)
	);

	// The queue never holds more than its depth.
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_count <= CNT_W'(QDEPTH))
		else $error("queue count beyond depth");

	// Only a window sequence runs past the second byte.
	a_short_kinds: assert property (@(posedge clk) disable iff (!arst_n)
		(q_rd_valid && !back_status.busy_window) |-> (back_status.idx <= 4'd1))
		else $error("byte counter out of range for a short request");

	// Retiring a descriptor always leaves its final word in the output register.
	a_pop_last: assert property (@(posedge clk) disable iff (!arst_n)
		back_status.pop |=> (m_tvalid && m_tlast))
		else $error("descriptor retired without a final word");

endmodule

>>> tb/dwp_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the display window pixel stream unit: watches both stream channels,
// predicts the panel bytes of every accepted request and compares them in order.
// Depends on dwp_pkg for the mode codes and the panel command bytes.
module dwp_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	// s_tdata, lowest bit up: start_col, start_row, win_width, win_height,
	// pixel_color, byte_value
	input  logic [95:0] s_tdata,
	// s_tuser: mode[2:0]
	input  logic [2:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	// m_tdata: out_byte[7:0]
	input  logic [7:0]  m_tdata,
	// m_tuser: is_data[0]
	input  logic        m_tuser,
	input  logic        m_tlast,
	output int          mismatches,
	output int          outstanding
);
	import dwp_pkg::*;

	typedef struct packed {
		logic [7:0] value;
		logic       is_data;
		logic       last;
	} panel_byte_t;

	panel_byte_t panel_bytes_due[$];
	int          fail_cnt = 0;
	int          due_cnt = 0;

	assign mismatches = fail_cnt;
	assign outstanding = due_cnt;

	function automatic panel_byte_t panel_byte(input logic [7:0] value, input logic is_data);
		panel_byte_t pb;
		pb.value = value;
		pb.is_data = is_data;
		pb.last = 1'b0;
		return pb;
	endfunction

	// Expands one request into the bytes the panel should see, tagging the final one.
	task automatic predict_panel_bytes(input logic [2:0] mode, input logic [95:0] d);
		panel_byte_t seq[$];
		logic [15:0] col_end;
		logic [15:0] row_end;
		logic [15:0] rgb;
		col_end = d[15:0] + d[47:32] - 16'd1;
		row_end = d[31:16] + d[63:48] - 16'd1;
		rgb = (mode == MODE_RGB888) ? {d[87:83], d[79:74], d[71:67]} : d[79:64];
		case (mode)
			MODE_WINDOW: begin
				seq.push_back(panel_byte(CMD_COLUMN_ADDR, 1'b0));
				seq.push_back(panel_byte(d[15:8], 1'b1));
				seq.push_back(panel_byte(d[7:0], 1'b1));
				seq.push_back(panel_byte(col_end[15:8], 1'b1));
				seq.push_back(panel_byte(col_end[7:0], 1'b1));
				seq.push_back(panel_byte(CMD_ROW_ADDR, 1'b0));
				seq.push_back(panel_byte(d[31:24], 1'b1));
				seq.push_back(panel_byte(d[23:16], 1'b1));
				seq.push_back(panel_byte(row_end[15:8], 1'b1));
				seq.push_back(panel_byte(row_end[7:0], 1'b1));
				seq.push_back(panel_byte(CMD_MEMORY_WRITE, 1'b0));
			end
			MODE_RGB565, MODE_RGB888: begin
				seq.push_back(panel_byte(rgb[15:8], 1'b1));
				seq.push_back(panel_byte(rgb[7:0], 1'b1));
			end
			MODE_ORIENT: begin
				seq.push_back(panel_byte(CMD_ORIENTATION, 1'b0));
				seq.push_back(panel_byte(d[95:88], 1'b1));
			end
			MODE_RAW_CMD: seq.push_back(panel_byte(d[95:88], 1'b0));
			MODE_RAW_DATA: seq.push_back(panel_byte(d[95:88], 1'b1));
			default: ;
		endcase
		if (seq.size() > 0)
			seq[seq.size() - 1].last = 1'b1;
		foreach (seq[i])
			panel_bytes_due.push_back(seq[i]);
	endtask

	// The output side is handled first: a word leaving at this edge can never
	// belong to a request taken at the same edge.
	always @(posedge clk) begin
		panel_byte_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (panel_bytes_due.size() == 0) begin
					fail_cnt++;
					$display("%0t: unexpected word byte=%h data=%b last=%b",
						$time, m_tdata, m_tuser, m_tlast);
				end else begin
					want = panel_bytes_due.pop_front();
					if (m_tdata !== want.value || m_tuser !== want.is_data ||
							m_tlast !== want.last) begin
						fail_cnt++;
						$display("%0t: word mismatch expected byte=%h data=%b last=%b, ",
							$time, want.value, want.is_data, want.last,
							"got byte=%h data=%b last=%b",
							m_tdata, m_tuser, m_tlast);
					end
				end
			end
			if (s_tvalid && s_tready)
				predict_panel_bytes(s_tuser, s_tdata);
			due_cnt = panel_bytes_due.size();
		end
	end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// Top of the testbench for the display window pixel stream unit: drives display
// requests and output back-pressure, and gives the verdict. Depends on dwp_pkg and dwp_checker.
module tb_top;
	import dwp_pkg::*;

	localparam int RANDOM_ITEMS = 150;
	// The limit is far above the slowest correct run: under 200 requests of at most 11 words each.
	localparam int CYCLE_LIMIT = 200000;
	// Cycles allowed after the last expected word for a stray word to show up.
	localparam int DRAIN_CYCLES = 16;
	// Undefined request mode; the block should accept it and emit nothing.
	localparam logic [2:0] MODE_UNDEFINED = 3'd6;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [95:0] s_tdata;
	logic [2:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;
	logic        m_tuser;
	logic        m_tlast;

	int mismatches;
	int outstanding;
	int cycles;

	// When set, the corresponding side never idles, so words flow back to back.
	bit sender_quiet;
	bit sink_quiet;

	display_window_pixel_stream_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	dwp_checker scoreboard (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.mismatches(mismatches),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Watchdog: a hang anywhere ends the run as a failure.
	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("TB_ERROR");
		$finish;
	end

	// Output back-pressure: before each word the sink may hold tready low for a
	// random stall, then keeps it high until a word is taken.
	initial begin
		int stall;
		m_tready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			stall = sink_quiet ? 0 : $urandom_range(0, 3);
			repeat (stall) begin
				m_tready <= 1'b0;
				@(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			@(negedge clk);
		end
	end

	function automatic logic [95:0] pack_request(input logic [15:0] col, input logic [15:0] row,
			input logic [15:0] wid, input logic [15:0] hgt, input logic [23:0] color,
			input logic [7:0] value);
		return {value, color, hgt, wid, row, col};
	endfunction

	function automatic logic [95:0] random_payload();
		return {$urandom, $urandom, $urandom};
	endfunction

	// Offers one request, after a random gap, and returns at the falling edge
	// following its acceptance. Called only at a falling edge.
	task automatic send_request(input logic [2:0] mode, input logic [95:0] d);
		int gap;
		gap = sender_quiet ? 0 : $urandom_range(0, 3);
		repeat (gap) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= mode;
		s_tdata <= d;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	// Holds the input side idle until every predicted word has left the block.
	task automatic wait_for_drain();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
	endtask

	// Random traffic shaped like real use: mostly pixels, some windows, a few
	// control bytes, and occasional undefined modes that do not count.
	task automatic send_random_traffic(input int count);
		int sent;
		int pick;
		logic [95:0] d;
		sent = 0;
		while (sent < count) begin
			pick = $urandom_range(0, 99);
			d = random_payload();
			if (pick < 40) begin
				send_request(MODE_RGB565, d);
				sent++;
			end else if (pick < 70) begin
				send_request(MODE_RGB888, d);
				sent++;
			end else if (pick < 82) begin
				// Sizes of zero and all ones bring out the wrap of the end coordinate.
				if ($urandom_range(0, 3) == 0)
					d[47:32] = 16'h0000;
				if ($urandom_range(0, 3) == 0)
					d[63:48] = 16'hFFFF;
				send_request(MODE_WINDOW, d);
				sent++;
			end else if (pick < 88) begin
				send_request(MODE_ORIENT, d);
				sent++;
			end else if (pick < 93) begin
				send_request(MODE_RAW_CMD, d);
				sent++;
			end else if (pick < 97) begin
				send_request(MODE_RAW_DATA, d);
				sent++;
			end else begin
				send_request(MODE_UNDEFINED | 3'($urandom_range(0, 1)), d);
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		sender_quiet = 1'b0;
		sink_quiet = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part. Windows: zero size wraps the end to start minus one,
		// all ones at the top of the range, a one-pixel window at the last
		// coordinate, and an ordinary window.
		send_request(MODE_WINDOW, pack_request(16'h0000, 16'h0000, 16'h0000, 16'h0000,
			24'hFFFFFF, 8'hFF));
		send_request(MODE_WINDOW, pack_request(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			24'h000000, 8'h00));
		send_request(MODE_WINDOW, pack_request(16'hFFFF, 16'hFFFF, 16'h0001, 16'h0001,
			24'h5A5A5A, 8'hA5));
		send_request(MODE_WINDOW, pack_request(16'h0010, 16'h0020, 16'h00F0, 16'h0140,
			24'h123456, 8'h3C));
		// RGB565 pixels; the top byte of the colour must be ignored.
		send_request(MODE_RGB565, pack_request(16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000,
			24'hFFFFFF, 8'hFF));
		send_request(MODE_RGB565, pack_request(16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF,
			24'h000000, 8'h00));
		send_request(MODE_RGB565, pack_request(16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0,
			24'hA5BEEF, 8'h81));
		// RGB888 pixels; low bits of each channel are truncated away.
		send_request(MODE_RGB888, pack_request(16'h0000, 16'h0000, 16'h0000, 16'h0000,
			24'hFFFFFF, 8'h00));
		send_request(MODE_RGB888, pack_request(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			24'h000000, 8'hFF));
		send_request(MODE_RGB888, pack_request(16'h0000, 16'h0000, 16'h0000, 16'h0000,
			24'h070307, 8'h00));
		send_request(MODE_RGB888, pack_request(16'h0000, 16'h0000, 16'h0000, 16'h0000,
			24'hF8FCF8, 8'h00));
		// Orientation, raw command and raw data at both extremes of the byte.
		send_request(MODE_ORIENT, pack_request(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			24'hFFFFFF, 8'h00));
		send_request(MODE_ORIENT, pack_request(16'h0000, 16'h0000, 16'h0000, 16'h0000,
			24'h000000, 8'hFF));
		send_request(MODE_RAW_CMD, pack_request(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			24'hFFFFFF, 8'h00));
		send_request(MODE_RAW_CMD, pack_request(16'h0000, 16'h0000, 16'h0000, 16'h0000,
			24'h000000, 8'hFF));
		send_request(MODE_RAW_DATA, pack_request(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			24'hFFFFFF, 8'h00));
		send_request(MODE_RAW_DATA, pack_request(16'h0000, 16'h0000, 16'h0000, 16'h0000,
			24'h000000, 8'hFF));
		// Undefined modes, wedged between other requests so a stray word would be noticed.
		send_request(MODE_UNDEFINED, random_payload());
		send_request(MODE_RGB565, random_payload());
		send_request(MODE_UNDEFINED | 3'd1, random_payload());
		send_request(MODE_RAW_DATA, random_payload());

		// The sender pauses here until every predicted word has come out.
		wait_for_drain();

		// Back to back on both sides, then a stalling sink against a greedy
		// sender to fill the queue, then the reverse, then both idling at random.
		sender_quiet = 1'b1;
		sink_quiet = 1'b1;
		send_random_traffic(40);
		sink_quiet = 1'b0;
		send_random_traffic(40);
		wait_for_drain();
		sender_quiet = 1'b0;
		sink_quiet = 1'b1;
		send_random_traffic(40);
		sink_quiet = 1'b0;
		send_random_traffic(RANDOM_ITEMS - 120);

		wait_for_drain();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

>>> files.f
hw/rtl/dwp_pkg.sv
hw/rtl/dwp_front.sv
hw/rtl/dwp_queue.sv
hw/rtl/dwp_back.sv
hw/rtl/display_window_pixel_stream_unit.sv
tb/dwp_checker.sv
tb/tb_top.sv
